/* rtl/core/twstat_pkg.sv */
package twstat_pkg;

   localparam int TIME_W      = 32;
   localparam int TEMP_W      = 8;
   localparam int SUM_W       = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   localparam int DEFAULT_WINDOW_SAMPLES = 24;

   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic [TIME_W-1:0]        time_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam temp_type RUN_MIN_RESET = temp_type'(99);
   localparam temp_type RUN_MAX_RESET = temp_type'(-99);
   localparam temp_type WIN_MIN_RESET = temp_type'(127);
   localparam temp_type WIN_MAX_RESET = temp_type'(-128);

   localparam time_type ACTUAL_INTERVAL_RESET = time_type'(1000);
   localparam time_type DAY_INTERVAL_RESET    = time_type'(3600000);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTUAL_INTERVAL = 1'b0,
      CSR_DAY_INTERVAL    = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type  cmd;
      time_type now_ms;
      temp_type sensor_temp;
   } req_type;

   typedef struct packed {
      temp_type actual_min;
      temp_type actual_max;
      logic     day_record_valid;
      temp_type day_avg;
      temp_type day_min;
      temp_type day_max;
      logic     history_clear;
   } rsp_type;

endpackage

/* rtl/core/twstat_avg_div.sv */
module twstat_avg_div
   import twstat_pkg::*;
#(
   parameter int DIVISOR = DEFAULT_WINDOW_SAMPLES
) (
   input  sum_type  sum,
   output temp_type quotient
);

   // Division by a constant as a multiplication by a rounded-up reciprocal.
   // With a shift of SUM_W plus the divisor's bit length, the rounding error
   // stays below one divisor step for every magnitude below 2^SUM_W, so the
   // truncated product equals the true floor of the magnitude's quotient.
   localparam int LOG_D = $clog2(DIVISOR);
   localparam int SHIFT = SUM_W + LOG_D;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   logic [SUM_W-1:0]  magnitude;
   logic [PROD_W-1:0] product;
   logic [SUM_W-1:0]  mag_quotient;
   logic [SUM_W-1:0]  signed_quotient;

   // Truncation toward zero: divide the magnitude, then restore the sign.
   assign magnitude       = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign product         = PROD_W'(magnitude) * PROD_W'(RECIP);
   assign mag_quotient    = SUM_W'(product >> SHIFT);
   assign signed_quotient = sum[SUM_W-1] ? SUM_W'(-mag_quotient) : mag_quotient;
   assign quotient        = temp_type'(signed_quotient[TEMP_W-1:0]);

endmodule

/* rtl/core/temperature_window_statistics_unit.sv */
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_stall  req_data  (cmd, now_ms, sensor_temp)
// rsp       out        rsp_valid/rsp_stall  rsp_data  (min/max, window record, clear)
// csr       in         csr_we               csr_index, csr_wdata
//
// Every request word yields exactly one response word; it passes through the
// request register and then the response register.
// A new word can be taken on every cycle while req_stall is low; the single update
// stage between the two registers reads and writes all statistics state.
// Reset is synchronous and active high, and restores the intervals and all
// statistics to their start values. A stall on rsp holds the response register
// and the request register, and req_stall rises only while both are full.
module temperature_window_statistics_unit
   import twstat_pkg::*;
#(
   parameter int WINDOW_SAMPLES = DEFAULT_WINDOW_SAMPLES
) (
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,

   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,

   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COUNT_W = $clog2(WINDOW_SAMPLES + 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(WINDOW_SAMPLES);

   // Configuration registers.
   time_type actual_interval_ff;
   time_type day_interval_ff;

   // Pipeline registers.
   logic    req_valid_ff;
   req_type req_word_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_word_ff;

   // Statistics state and its next values.
   temp_type           run_min_ff,      run_min_in;
   temp_type           run_max_ff,      run_max_in;
   time_type           last_actual_ff,  last_actual_in;
   time_type           last_day_ff,     last_day_in;
   logic [COUNT_W-1:0] win_count_ff,    win_count_in;
   sum_type            win_sum_ff,      win_sum_in;
   temp_type           win_min_ff,      win_min_in;
   temp_type           win_max_ff,      win_max_in;

   rsp_type  rsp_word_in;
   logic     rsp_free;
   logic     advance;
   logic     req_take;
   logic     is_clear;
   logic     actual_due;
   logic     day_due;
   logic     window_full;
   logic     emit_record;
   logic     take_sample;
   temp_type sample;
   temp_type window_avg;

   // The response register is free when empty or being drained this cycle.
   // The update stage moves a word on whenever it holds one and there is room.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // Average of the completed window, from the accumulated sum.
   twstat_avg_div #(
      .DIVISOR (WINDOW_SAMPLES)
   ) u_avg_div (
      .sum      (win_sum_ff),
      .quotient (window_avg)
   );

   // Probe decisions. The time differences wrap, so an interval is measured
   // correctly across a rollover of the millisecond counter. A clear word
   // takes no probe at all.
   assign sample      = req_word_ff.sensor_temp;
   assign is_clear    = (req_word_ff.cmd == CMD_CLEAR);
   assign actual_due  = !is_clear &&
                        ((req_word_ff.now_ms - last_actual_ff) >= actual_interval_ff);
   assign day_due     = !is_clear &&
                        ((req_word_ff.now_ms - last_day_ff) >= day_interval_ff);
   assign window_full = (win_count_ff == COUNT_FULL);
   assign emit_record = day_due && window_full;
   assign take_sample = day_due && !window_full;

   always_comb begin
      run_min_in     = run_min_ff;
      run_max_in     = run_max_ff;
      last_actual_in = last_actual_ff;
      last_day_in    = last_day_ff;
      win_count_in   = win_count_ff;
      win_sum_in     = win_sum_ff;
      win_min_in     = win_min_ff;
      win_max_in     = win_max_ff;

      // Running minimum and maximum since reset or the last clear.
      if (is_clear) begin
         run_min_in = RUN_MIN_RESET;
         run_max_in = RUN_MAX_RESET;
      end else if (actual_due) begin
         last_actual_in = req_word_ff.now_ms;
         if (sample < run_min_ff) begin
            run_min_in = sample;
         end
         if (sample > run_max_ff) begin
            run_max_in = sample;
         end
      end

      // A day probe on a full window closes it instead of sampling.
      if (day_due) begin
         last_day_in = req_word_ff.now_ms;
      end
      if (emit_record) begin
         win_count_in = '0;
         win_sum_in   = '0;
         win_min_in   = WIN_MIN_RESET;
         win_max_in   = WIN_MAX_RESET;
      end else if (take_sample) begin
         win_count_in = win_count_ff + COUNT_W'(1);
         win_sum_in   = win_sum_ff + sum_type'(sample);
         if (sample < win_min_ff) begin
            win_min_in = sample;
         end
         if (sample > win_max_ff) begin
            win_max_in = sample;
         end
      end
   end

   // The response carries the running values after this word and, only when
   // a window closes, its record; otherwise the record fields read as zero.
   always_comb begin
      rsp_word_in.actual_min       = run_min_in;
      rsp_word_in.actual_max       = run_max_in;
      rsp_word_in.day_record_valid = emit_record;
      rsp_word_in.day_avg          = emit_record ? window_avg : '0;
      rsp_word_in.day_min          = emit_record ? win_min_ff : '0;
      rsp_word_in.day_max          = emit_record ? win_max_ff : '0;
      rsp_word_in.history_clear    = is_clear;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         actual_interval_ff <= ACTUAL_INTERVAL_RESET;
         day_interval_ff    <= DAY_INTERVAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTUAL_INTERVAL: actual_interval_ff <= csr_wdata[TIME_W-1:0];
            CSR_DAY_INTERVAL:    day_interval_ff    <= csr_wdata[TIME_W-1:0];
            default:             actual_interval_ff <= actual_interval_ff;
         endcase
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_word_ff <= req_data;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Statistics state moves only together with the word that caused it.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff     <= RUN_MIN_RESET;
         run_max_ff     <= RUN_MAX_RESET;
         last_actual_ff <= '0;
         last_day_ff    <= '0;
         win_count_ff   <= '0;
         win_sum_ff     <= '0;
         win_min_ff     <= WIN_MIN_RESET;
         win_max_ff     <= WIN_MAX_RESET;
      end else if (advance) begin
         run_min_ff     <= run_min_in;
         run_max_ff     <= run_max_in;
         last_actual_ff <= last_actual_in;
         last_day_ff    <= last_day_in;
         win_count_ff   <= win_count_in;
         win_sum_ff     <= win_sum_in;
         win_min_ff     <= win_min_in;
         win_max_ff     <= win_max_in;
      end
   end

endmodule

/* tb/temperature_window_statistics_unit_tb.sv */
module temperature_window_statistics_unit_tb;
   import twstat_pkg::*;

   // The block is built with its default window length, so the predictor uses the same.
   localparam int WINDOW          = DEFAULT_WINDOW_SAMPLES;
   localparam int PHASES          = 5;
   localparam int WORDS_PER_PHASE = 78;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int IDLE_LIMIT      = 2000;
   localparam int TAIL_CYCLES     = 8;
   localparam int MAX_REPORTS     = 10;

   typedef enum logic {
      ROW_WORD,
      ROW_CSR
   } row_kind_type;

   // One line of the directed table: either a request word sent reps times, or a
   // register write. Where typed is set, the response word is taken from want
   // instead of from the predictor.
   typedef struct {
      row_kind_type  kind;
      csr_index_type index;
      logic [CSR_DATA_W-1:0] value;
      req_type       word;
      int            reps;
      bit            typed;
      rsp_type       want;
   } dir_row_type;

   logic          clock;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we    = 1'b0;
   csr_index_type csr_index = CSR_ACTUAL_INTERVAL;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   temperature_window_statistics_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the statistics state and of both interval registers. It is
   // advanced once for every request word the block takes, in the order taken.
   temp_type stat_lo;
   temp_type stat_hi;
   time_type probe_at_actual;
   time_type probe_at_day;
   int       win_count;
   sum_type  win_sum;
   temp_type win_lo;
   temp_type win_hi;
   time_type iv_actual;
   time_type iv_day;

   rsp_type     expected_words[$];
   dir_row_type dir_rows[$];
   int          mismatches      = 0;
   int          idle_cycles     = 0;
   int          burst_left      = 0;
   bit          hold_off_wanted = 1'b0;
   bit          hold_off_done   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void empty_window();
      win_count = 0;
      win_sum   = '0;
      win_lo    = WIN_MIN_RESET;
      win_hi    = WIN_MAX_RESET;
   endfunction

   function automatic void statistics_reset();
      stat_lo         = RUN_MIN_RESET;
      stat_hi         = RUN_MAX_RESET;
      probe_at_actual = '0;
      probe_at_day    = '0;
      iv_actual       = ACTUAL_INTERVAL_RESET;
      iv_day          = DAY_INTERVAL_RESET;
      empty_window();
   endfunction

   // Works out the response word for one request word and moves the shadow state on.
   // Both probes use the wrapping distance from the time of the previous probe.
   function automatic rsp_type predict_statistics(input req_type w);
      rsp_type r;
      r = '0;
      if (w.cmd == CMD_CLEAR) begin
         // A clear touches only the running extremes; times and window stay.
         stat_lo         = RUN_MIN_RESET;
         stat_hi         = RUN_MAX_RESET;
         r.history_clear = 1'b1;
      end else begin
         if (time_type'(w.now_ms - probe_at_actual) >= iv_actual) begin
            probe_at_actual = w.now_ms;
            if (w.sensor_temp < stat_lo) stat_lo = w.sensor_temp;
            if (w.sensor_temp > stat_hi) stat_hi = w.sensor_temp;
         end
         if (time_type'(w.now_ms - probe_at_day) >= iv_day) begin
            probe_at_day = w.now_ms;
            if (win_count == WINDOW) begin
               // A full window is reported in place of taking the sample.
               r.day_record_valid = 1'b1;
               r.day_avg          = temp_type'(win_sum / WINDOW);
               r.day_min          = win_lo;
               r.day_max          = win_hi;
               empty_window();
            end else begin
               win_sum = win_sum + sum_type'(w.sensor_temp);
               win_count++;
               if (w.sensor_temp < win_lo) win_lo = w.sensor_temp;
               if (w.sensor_temp > win_hi) win_hi = w.sensor_temp;
            end
         end
      end
      r.actual_min = stat_lo;
      r.actual_max = stat_hi;
      return r;
   endfunction

   function automatic rsp_type rsp_of(input int lo, input int hi, input bit rec,
                                      input int avg, input int dlo, input int dhi,
                                      input bit clr);
      rsp_type r;
      r.actual_min       = temp_type'(lo);
      r.actual_max       = temp_type'(hi);
      r.day_record_valid = rec;
      r.day_avg          = temp_type'(avg);
      r.day_min          = temp_type'(dlo);
      r.day_max          = temp_type'(dhi);
      r.history_clear    = clr;
      return r;
   endfunction

   function automatic dir_row_type word_row(input cmd_type c, input time_type t,
                                            input int temp, input int reps,
                                            input bit typed, input rsp_type want);
      dir_row_type row;
      row.kind             = ROW_WORD;
      row.index            = CSR_ACTUAL_INTERVAL;
      row.value            = '0;
      row.word.cmd         = c;
      row.word.now_ms      = t;
      row.word.sensor_temp = temp_type'(temp);
      row.reps             = reps;
      row.typed            = typed;
      row.want             = want;
      return row;
   endfunction

   function automatic dir_row_type csr_row(input csr_index_type idx,
                                           input logic [CSR_DATA_W-1:0] value);
      dir_row_type row;
      row       = word_row(CMD_TICK, '0, 0, 0, 1'b0, '0);
      row.kind  = ROW_CSR;
      row.index = idx;
      row.value = value;
      return row;
   endfunction

   // Offers one request word and returns at the falling edge after it was taken.
   // It is always entered at a falling edge. The sender works in bursts; between
   // bursts valid drops for a random number of cycles. Back-to-back words keep
   // valid high, so valid is assigned only once in any time step.
   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type predicted;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_statistics(w);
      expected_words.push_back(typed ? want : predicted);
      burst_left--;
      @(negedge clock);
   endtask

   // Takes valid away and waits until every response word that is owed has
   // arrived. It always waits for a falling edge first, so that valid is never
   // lowered and raised again within the same time step.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_words.size() != 0);
   endtask

   // Register write, made only while the block holds no word. The shadow copy
   // follows once the write edge has passed.
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ACTUAL_INTERVAL) iv_actual = value;
      else iv_day = value;
      @(negedge clock);
   endtask

   // Response side: a pattern of its own, built from segments that never stall,
   // stall now and then, or stall most of the time. Once the sender asks for it,
   // one long hold-off is made so that both internal registers fill and the
   // request side has to stall.
   initial begin : response_stall
      int seg_left;
      int mode;
      int hold_left;
      seg_left  = 0;
      mode      = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_wanted && !hold_off_done && hold_left == 0) hold_left = HOLD_OFF_CYCLES;
         if (hold_left != 0) begin
            hold_left--;
            if (hold_left == 0) hold_off_done = 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 2);
               seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
            endcase
         end
      end
   end

   // Every response word taken is compared, field by field, with the oldest
   // expectation. A word with nothing owed counts as a mismatch as well.
   always @(posedge clock) begin : check_response
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response word: min %0d max %0d rec %0b avg %0d lo %0d hi %0d clr %0b",
                        rsp_data.actual_min, rsp_data.actual_max, rsp_data.day_record_valid,
                        rsp_data.day_avg, rsp_data.day_min, rsp_data.day_max,
                        rsp_data.history_clear);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.actual_min !== want.actual_min ||
                rsp_data.actual_max !== want.actual_max ||
                rsp_data.day_record_valid !== want.day_record_valid ||
                rsp_data.day_avg !== want.day_avg ||
                rsp_data.day_min !== want.day_min ||
                rsp_data.day_max !== want.day_max ||
                rsp_data.history_clear !== want.history_clear) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("response mismatch, expected: min %0d max %0d rec %0b avg %0d lo %0d hi %0d clr %0b",
                           want.actual_min, want.actual_max, want.day_record_valid,
                           want.day_avg, want.day_min, want.day_max, want.history_clear);
                  $display("                   actual:   min %0d max %0d rec %0b avg %0d lo %0d hi %0d clr %0b",
                           rsp_data.actual_min, rsp_data.actual_max, rsp_data.day_record_valid,
                           rsp_data.day_avg, rsp_data.day_min, rsp_data.day_max,
                           rsp_data.history_clear);
               end
            end
         end
      end
   end

   // The run is ended if neither channel nor the register port moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("temperature_window_statistics_unit_tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      req_type  w;
      time_type cursor;
      time_type step_hi;
      int       ph;
      int       n;
      int       k;
      int       roll;

      statistics_reset();
      cursor = '0;

      // Directed table. The first rows run with the intervals as they come out of
      // reset; then both intervals go to zero, so that every tick probes and full
      // windows are reported; last, both go to their largest value, where only a
      // time one below the previous probe is far enough away.
      dir_rows.push_back(word_row(CMD_TICK, 32'd0, 5, 1, 1'b1,
                                  rsp_of(99, -99, 1'b0, 0, 0, 0, 1'b0)));
      dir_rows.push_back(word_row(CMD_TICK, 32'd1000, -128, 1, 1'b1,
                                  rsp_of(-128, -99, 1'b0, 0, 0, 0, 1'b0)));
      dir_rows.push_back(word_row(CMD_TICK, 32'd2000, 127, 1, 1'b1,
                                  rsp_of(-128, 127, 1'b0, 0, 0, 0, 1'b0)));
      // A clear ignores its time and temperature, even at their extremes.
      dir_rows.push_back(word_row(CMD_CLEAR, 32'hFFFF_FFFF, -1, 1, 1'b1,
                                  rsp_of(99, -99, 1'b0, 0, 0, 0, 1'b1)));
      dir_rows.push_back(word_row(CMD_TICK, 32'd2999, 0, 1, 1'b1,
                                  rsp_of(99, -99, 1'b0, 0, 0, 0, 1'b0)));
      dir_rows.push_back(word_row(CMD_TICK, 32'd3000, 0, 1, 1'b1,
                                  rsp_of(0, 0, 1'b0, 0, 0, 0, 1'b0)));
      dir_rows.push_back(word_row(CMD_TICK, 32'd3600000, -1, 1, 1'b1,
                                  rsp_of(-1, 0, 1'b0, 0, 0, 0, 1'b0)));
      dir_rows.push_back(csr_row(CSR_ACTUAL_INTERVAL, '0));
      dir_rows.push_back(csr_row(CSR_DAY_INTERVAL, '0));
      // Top up the window with the coldest value, then report it: a negative average.
      dir_rows.push_back(word_row(CMD_TICK, 32'd0, -128, WINDOW - 1, 1'b0, '0));
      dir_rows.push_back(word_row(CMD_TICK, 32'd0, 0, 1, 1'b0, '0));
      // A window of nothing but the hottest value.
      dir_rows.push_back(word_row(CMD_TICK, 32'd0, 127, WINDOW, 1'b0, '0));
      dir_rows.push_back(word_row(CMD_TICK, 32'd0, 127, 1, 1'b1,
                                  rsp_of(-128, 127, 1'b1, 127, 127, 127, 1'b0)));
      dir_rows.push_back(csr_row(CSR_ACTUAL_INTERVAL, '1));
      dir_rows.push_back(csr_row(CSR_DAY_INTERVAL, '1));
      dir_rows.push_back(word_row(CMD_CLEAR, 32'd0, -128, 1, 1'b1,
                                  rsp_of(99, -99, 1'b0, 0, 0, 0, 1'b1)));
      dir_rows.push_back(word_row(CMD_TICK, 32'hFFFF_FFFF, 7, 1, 1'b1,
                                  rsp_of(7, 7, 1'b0, 0, 0, 0, 1'b0)));
      dir_rows.push_back(word_row(CMD_TICK, 32'd0, 8, 1, 1'b1,
                                  rsp_of(7, 7, 1'b0, 0, 0, 0, 1'b0)));
      dir_rows.push_back(word_row(CMD_TICK, 32'hFFFF_FFFE, -3, 1, 1'b1,
                                  rsp_of(-3, 7, 1'b0, 0, 0, 0, 1'b0)));

      // Reset is held high from the start and released at a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            wait_for_drain();
            csr_write(dir_rows[i].index, dir_rows[i].value);
         end else begin
            for (k = 0; k < dir_rows[i].reps; k++)
               send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // Random phases, each with its own pair of intervals. Most words are ticks whose
      // time moves forward from a cursor by steps that suit the intervals, or with the
      // largest intervals lies one below a previous probe, so that probes and full
      // windows keep coming; the rest are clears and ticks at an arbitrary time.
      for (ph = 0; ph < PHASES; ph++) begin
         wait_for_drain();
         case (ph)
            0: begin
               csr_write(CSR_ACTUAL_INTERVAL, '0);
               csr_write(CSR_DAY_INTERVAL, '0);
               step_hi = 3;
            end
            1: begin
               csr_write(CSR_ACTUAL_INTERVAL, $urandom_range(1, 30));
               csr_write(CSR_DAY_INTERVAL, $urandom_range(1, 4));
               step_hi = 6;
            end
            2: begin
               csr_write(CSR_ACTUAL_INTERVAL, '1);
               csr_write(CSR_DAY_INTERVAL, '1);
               step_hi = 0;
            end
            3: begin
               csr_write(CSR_ACTUAL_INTERVAL, ACTUAL_INTERVAL_RESET);
               csr_write(CSR_DAY_INTERVAL, DAY_INTERVAL_RESET);
               step_hi = 4000000;
            end
            default: begin
               csr_write(CSR_ACTUAL_INTERVAL, $urandom);
               csr_write(CSR_DAY_INTERVAL, $urandom);
               step_hi = '1;
            end
         endcase
         // The long hold-off on the response side falls in the first phase, while
         // words keep being offered.
         if (ph == 0) hold_off_wanted = 1'b1;

         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            roll          = $urandom_range(0, 99);
            w.cmd         = CMD_TICK;
            w.sensor_temp = temp_type'($urandom);
            if ($urandom_range(0, 9) == 0)
               w.sensor_temp = $urandom_range(0, 1) ? WIN_MIN_RESET : WIN_MAX_RESET;
            if (roll < 5) begin
               w.cmd    = CMD_CLEAR;
               w.now_ms = $urandom;
            end else if (roll < 12) begin
               w.now_ms = $urandom;
            end else if (ph == 2) begin
               // With the largest intervals, a probe needs a time just one below
               // the previous probe of that kind.
               w.now_ms = ($urandom_range(0, 1) ? probe_at_actual : probe_at_day) - 1'b1;
            end else begin
               cursor   = cursor + time_type'($urandom_range(0, step_hi));
               w.now_ms = cursor;
            end
            // Now and then the sender waits until every owed word has come back.
            if ($urandom_range(0, 49) == 0) wait_for_drain();
            send_word(w, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("temperature_window_statistics_unit_tb: clean");
      end else begin
         $display("temperature_window_statistics_unit_tb: errors");
      end
      $finish;
   end

endmodule

/* temperature_window_statistics_unit.f */
rtl/core/twstat_pkg.sv
rtl/core/twstat_avg_div.sv
rtl/core/temperature_window_statistics_unit.sv
tb/temperature_window_statistics_unit_tb.sv
